// ----- hw/rtl/skt_pkg.sv -----
// Shared types and codes for the sorted key table.
// No dependencies; every other file of the block but skt_ram uses it.
`timescale 1ns / 1ps

package skt_pkg;

	localparam int DEF_TABLE_DEPTH = 256;
	localparam int DEF_KEY_WIDTH   = 32;

	localparam int OP_W     = 2;
	localparam int IDX_W    = 8;
	localparam int KEYIO_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [OP_W-1:0] OP_SET    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_SORT   = 2'd2;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [IDX_W-1:0]   entry_index;
		logic [KEYIO_W-1:0] key_value;
		logic [IDX_W-1:0]   range_low;
		logic [IDX_W-1:0]   range_high;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [IDX_W-1:0]    found_index;
		logic [KEYIO_W-1:0]  removed_key;
	} res_t;

endpackage

// ----- hw/rtl/skt_if.sv -----
// Request and response channel interfaces of the sorted key table.
// Depends on skt_pkg for field widths.
`timescale 1ns / 1ps

interface skt_req_if;
	logic                       valid;
	logic                       ready;
	logic [skt_pkg::OP_W-1:0]    operation;
	logic [skt_pkg::IDX_W-1:0]   entry_index;
	logic [skt_pkg::KEYIO_W-1:0] key_value;
	logic [skt_pkg::IDX_W-1:0]   range_low;
	logic [skt_pkg::IDX_W-1:0]   range_high;
	modport source (output valid, operation, entry_index, key_value, range_low, range_high,
		input ready);
	modport sink (input valid, operation, entry_index, key_value, range_low, range_high,
		output ready);
endinterface

interface skt_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [skt_pkg::STATUS_W-1:0] status;
	logic [skt_pkg::IDX_W-1:0]    found_index;
	logic [skt_pkg::KEYIO_W-1:0]  removed_key;
	modport source (output valid, status, found_index, removed_key, input ready);
	modport sink (input valid, status, found_index, removed_key, output ready);
endinterface

// ----- hw/rtl/skt_ram.sv -----
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the key store and the range stack. No package dependency.
`timescale 1ns / 1ps

module skt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- hw/rtl/skt_seq.sv -----
// Sequencer of the sorted key table: clear pass, set/remove, quicksort, find.
// One shared key comparator; drives the key RAM and stack RAM. Uses skt_pkg.
`timescale 1ns / 1ps

module skt_seq #(
	parameter int TABLE_DEPTH = 256,
	parameter int KEY_WIDTH   = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  skt_pkg::req_t                     req,
	input  logic                              slot_free,
	output logic                              done,
	output skt_pkg::res_t                     res,
	output logic                              kwe,
	output logic [$clog2(TABLE_DEPTH)-1:0]    kwa,
	output logic [KEY_WIDTH-1:0]              kwd,
	output logic [$clog2(TABLE_DEPTH)-1:0]    kra,
	input  logic [KEY_WIDTH-1:0]              krd,
	output logic                              swe,
	output logic [$clog2(TABLE_DEPTH)-1:0]    swa,
	output logic [2*$clog2(TABLE_DEPTH)-1:0]  swd,
	output logic [$clog2(TABLE_DEPTH)-1:0]    sra,
	input  logic [2*$clog2(TABLE_DEPTH)-1:0]  srd
);
	import skt_pkg::*;

	localparam int AW   = $clog2(TABLE_DEPTH);
	localparam int CNTW = $clog2(TABLE_DEPTH + 1);
	localparam int IXW  = ((CNTW > IDX_W + 1) ? CNTW : IDX_W + 1) + 1;
	localparam logic signed [IXW-1:0] DEPTH_X = IXW'(TABLE_DEPTH);
	localparam logic signed [IXW-1:0] ONE_X   = IXW'(1);
	localparam logic signed [IXW-1:0] TWO_X   = IXW'(2);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_RM_RD, S_POP, S_POP_WAIT, S_PIV, S_SCAN_I, S_SCAN_J,
		S_SWAP2, S_PUSH1, S_PUSH2, S_FD_LOOP, S_FD_CMP, S_FD_SCAN, S_FINISH
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [CNTW-1:0]         count_q;
	logic [CNTW-1:0]         sp_q;
	logic [KEY_WIDTH-1:0]    key_q, pivot_q, ki_q;
	logic signed [IXW-1:0]   i_q, j_q, left_q, right_q, lo_q, hi_q, mid_q;
	logic [STATUS_W-1:0]     status_q;
	logic [IDX_W-1:0]        found_q;
	logic [KEYIO_W-1:0]      removed_q;

	// request decode
	logic [KEY_WIDTH+KEYIO_W-1:0] kin_ext;
	logic [KEY_WIDTH-1:0]         key_in;
	logic signed [IXW-1:0]        idx_x, rlo_x, rhi_x;
	logic                         range_bad, set_bad, rm_bad;
	logic [KEY_WIDTH+KEYIO_W-1:0] rm_ext;

	assign kin_ext   = {{KEY_WIDTH{1'b0}}, req.key_value};
	assign key_in    = kin_ext[KEY_WIDTH-1:0];
	assign idx_x     = signed'(IXW'(req.entry_index));
	assign rlo_x     = signed'(IXW'(req.range_low));
	assign rhi_x     = signed'(IXW'(req.range_high));
	assign set_bad   = idx_x >= DEPTH_X;
	assign rm_bad    = set_bad || (idx_x >= signed'(IXW'(count_q)));
	assign range_bad = (rhi_x >= DEPTH_X) || (rlo_x > rhi_x);
	assign rm_ext    = {{KEYIO_W{1'b0}}, krd};

	// popped range and its midpoint
	logic signed [IXW-1:0] pop_lo, pop_hi;
	logic [AW:0]           pop_sum;
	assign pop_lo  = signed'(IXW'(srd[2*AW-1:AW]));
	assign pop_hi  = signed'(IXW'(srd[AW-1:0]));
	assign pop_sum = {1'b0, srd[2*AW-1:AW]} + {1'b0, srd[AW-1:0]};

	logic signed [IXW-1:0] i_nx, j_nx, lo_nx, fd_mid;
	assign i_nx   = i_q + ONE_X;
	assign j_nx   = j_q - ONE_X;
	assign lo_nx  = lo_q + ONE_X;
	assign fd_mid = lo_q + ((hi_q - lo_q) >>> 1);

	// shared comparator
	logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
	logic                 lt;
	always_comb begin
		case (state_q)
			S_SCAN_I:  begin cmp_a = krd;     cmp_b = pivot_q; end
			S_SCAN_J:  begin cmp_a = pivot_q; cmp_b = krd;     end
			S_FD_CMP:  begin cmp_a = key_q;   cmp_b = krd;     end
			default:   begin cmp_a = krd;     cmp_b = key_q;   end
		endcase
	end
	assign lt = cmp_a < cmp_b;

	logic scan_i_go, scan_j_go, push_l, push_r, stack_room;
	assign scan_i_go  = (i_q < right_q) && lt;
	assign scan_j_go  = (j_q > left_q) && lt;
	assign stack_room = sp_q < CNTW'(TABLE_DEPTH);
	assign push_l     = (left_q < j_q) && stack_room;
	assign push_r     = (i_q < right_q) && stack_room;

	assign req_ready = state_q == S_IDLE;
	assign done      = (state_q == S_FINISH) && slot_free;
	assign res       = '{status: status_q, found_index: found_q, removed_key: removed_q};

	// RAM port control
	always_comb begin
		kwe = 1'b0;
		kwa = i_q[AW-1:0];
		kwd = '0;
		kra = i_q[AW-1:0];
		swe = 1'b0;
		swa = sp_q[AW-1:0];
		swd = {left_q[AW-1:0], j_q[AW-1:0]};
		sra = '0;
		case (state_q)
			S_CLEAR: begin
				kwe = 1'b1;
				kwa = clr_q;
			end
			S_IDLE: begin
				kwa = idx_x[AW-1:0];
				kwd = key_in;
				kra = idx_x[AW-1:0];
				swa = '0;
				swd = {rlo_x[AW-1:0], rhi_x[AW-1:0]};
				if (req_valid && req.operation == OP_SET && !set_bad) begin
					kwe = 1'b1;
				end
				if (req_valid && req.operation == OP_SORT && !range_bad && rlo_x < rhi_x) begin
					swe = 1'b1;
				end
			end
			S_RM_RD: begin
				kwe = 1'b1;
			end
			S_POP: begin
				sra = AW'(sp_q - CNTW'(1));
			end
			S_POP_WAIT: begin
				kra = pop_sum[AW:1];
			end
			S_PIV: begin
				kra = left_q[AW-1:0];
			end
			S_SCAN_I: begin
				kra = scan_i_go ? i_nx[AW-1:0] : j_q[AW-1:0];
			end
			S_SCAN_J: begin
				kra = j_nx[AW-1:0];
				kwd = krd;
				if (!scan_j_go && j_q >= i_q) begin
					kwe = 1'b1;
				end
			end
			S_SWAP2: begin
				kwe = 1'b1;
				kwa = j_q[AW-1:0];
				kwd = ki_q;
				kra = i_nx[AW-1:0];
			end
			S_PUSH1: begin
				swe = push_l;
			end
			S_PUSH2: begin
				swe = push_r;
				swd = {i_q[AW-1:0], right_q[AW-1:0]};
			end
			S_FD_LOOP: begin
				kra = (hi_q - lo_q > TWO_X) ? fd_mid[AW-1:0] : lo_q[AW-1:0];
			end
			S_FD_SCAN: begin
				kra = lo_nx[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			sp_q    <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					status_q  <= ST_OK;
					found_q   <= '0;
					removed_q <= '0;
					key_q     <= key_in;
					i_q       <= idx_x;
					lo_q      <= rlo_x;
					hi_q      <= rhi_x;
					if (req_valid) begin
						state_q <= S_FINISH;
						case (req.operation)
							OP_SET: begin
								if (set_bad) begin
									status_q <= ST_REJECT;
								end else if (idx_x >= signed'(IXW'(count_q))) begin
									count_q <= CNTW'(idx_x + ONE_X);
								end
							end
							OP_REMOVE: begin
								if (rm_bad) begin
									status_q <= ST_REJECT;
								end else begin
									state_q <= S_RM_RD;
								end
							end
							OP_SORT: begin
								if (range_bad) begin
									status_q <= ST_REJECT;
								end else if (rlo_x < rhi_x) begin
									sp_q    <= CNTW'(1);
									state_q <= S_POP;
								end
							end
							default: begin
								if (range_bad) begin
									status_q <= ST_REJECT;
								end else begin
									state_q <= S_FD_LOOP;
								end
							end
						endcase
					end
				end
				S_RM_RD: begin
					removed_q <= rm_ext[KEYIO_W-1:0];
					state_q   <= S_FINISH;
				end
				S_POP: begin
					if (sp_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						sp_q    <= sp_q - CNTW'(1);
						state_q <= S_POP_WAIT;
					end
				end
				S_POP_WAIT: begin
					left_q  <= pop_lo;
					right_q <= pop_hi;
					state_q <= S_PIV;
				end
				S_PIV: begin
					pivot_q <= krd;
					i_q     <= left_q;
					j_q     <= right_q;
					state_q <= S_SCAN_I;
				end
				S_SCAN_I: begin
					if (scan_i_go) begin
						i_q <= i_nx;
					end else begin
						ki_q    <= krd;
						state_q <= S_SCAN_J;
					end
				end
				S_SCAN_J: begin
					if (scan_j_go) begin
						j_q <= j_nx;
					end else if (j_q < i_q) begin
						state_q <= S_PUSH1;
					end else begin
						state_q <= S_SWAP2;
					end
				end
				S_SWAP2: begin
					i_q     <= i_nx;
					j_q     <= j_nx;
					state_q <= (i_nx <= j_nx) ? S_SCAN_I : S_PUSH1;
				end
				S_PUSH1: begin
					if (push_l) begin
						sp_q <= sp_q + CNTW'(1);
					end
					state_q <= S_PUSH2;
				end
				S_PUSH2: begin
					if (push_r) begin
						sp_q <= sp_q + CNTW'(1);
					end
					state_q <= S_POP;
				end
				S_FD_LOOP: begin
					mid_q   <= fd_mid;
					state_q <= (hi_q - lo_q > TWO_X) ? S_FD_CMP : S_FD_SCAN;
				end
				S_FD_CMP: begin
					if (lt) begin
						hi_q <= mid_q;
					end else begin
						lo_q <= mid_q;
					end
					state_q <= S_FD_LOOP;
				end
				S_FD_SCAN: begin
					if (!lt) begin
						// first key not below the target
						if (krd == key_q) begin
							found_q <= lo_q[IDX_W-1:0];
						end else begin
							status_q <= ST_MISSING;
						end
						state_q <= S_FINISH;
					end else if (lo_nx > hi_q) begin
						status_q <= ST_MISSING;
						state_q  <= S_FINISH;
					end else begin
						lo_q <= lo_nx;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CNTW'(TABLE_DEPTH))
		else $error("range stack overran");
	a_i_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_I |-> (i_q <= right_q && i_q >= left_q))
		else $error("left scan left its range");
	a_j_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN_J |-> (j_q >= left_q && j_q <= right_q))
		else $error("right scan left its range");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == S_IDLE && !done)
		else $error("result finished twice");
`endif

endmodule

// ----- hw/rtl/sorted_key_table_top.sv -----
// Top level of the sorted key table: sequencer, key RAM, stack RAM, result register.
// Depends on skt_pkg, skt_if, skt_ram and skt_seq.
`timescale 1ns / 1ps

// The sorted key table keeps TABLE_DEPTH unsigned keys in one RAM and takes one
// request at a time, giving one response per request. After reset a clearing
// pass zeroes the key RAM, one slot per cycle, and req.ready stays low until the
// pass is done. Set writes its slot when taken; remove reads the old key, then
// clears the slot. Sort and find step a single shared key comparator against
// the one read port of the key RAM: a find halves its range while the span is
// above two, then scans slot by slot; a sort is a quicksort whose partition
// scans read one slot at a time, with swaps and subranges popped from the
// range stack. A response waits in its own register, so the next request is
// taken while that response is still not taken; req.ready is high only while
// the sequencer is idle.
module sorted_key_table_top #(
	parameter int TABLE_DEPTH = skt_pkg::DEF_TABLE_DEPTH,
	parameter int KEY_WIDTH   = skt_pkg::DEF_KEY_WIDTH
) (
	input logic     clk,
	input logic     arst_n,
	skt_req_if.sink   req,
	skt_rsp_if.source rsp
);
	import skt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	req_t                 req_s;
	res_t                 res_c, res_q;
	logic                 rsp_valid_q;
	logic                 slot_free;
	logic                 done;

	// key RAM ports
	logic                 kwe;
	logic [AW-1:0]        kwa, kra;
	logic [KEY_WIDTH-1:0] kwd, krd;

	// range stack ports: each entry holds a low and a high slot
	logic                 swe;
	logic [AW-1:0]        swa, sra;
	logic [2*AW-1:0]      swd, srd;

	assign req_s = '{operation: req.operation, entry_index: req.entry_index,
		key_value: req.key_value, range_low: req.range_low, range_high: req.range_high};

	// response slot frees when empty or being drained this cycle
	assign slot_free = !rsp_valid_q || rsp.ready;

	skt_seq #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req       (req_s),
		.slot_free (slot_free),
		.done      (done),
		.res       (res_c),
		.kwe       (kwe),
		.kwa       (kwa),
		.kwd       (kwd),
		.kra       (kra),
		.krd       (krd),
		.swe       (swe),
		.swa       (swa),
		.swd       (swd),
		.sra       (sra),
		.srd       (srd)
	);

	skt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_DEPTH)) u_key_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (kwa),
		.wdata (kwd),
		.raddr (kra),
		.rdata (krd)
	);

	skt_ram #(.WIDTH(2 * AW), .DEPTH(TABLE_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (swe),
		.waddr (swa),
		.wdata (swd),
		.raddr (sra),
		.rdata (srd)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res_c;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = res_q.status;
	assign rsp.found_index = res_q.found_index;
	assign rsp.removed_key = res_q.removed_key;

`ifndef ASSERT_OFF
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> slot_free)
		else $error("response overwritten");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_REJECT ||
			rsp.status == ST_MISSING))
		else $error("bad status code");
`endif

endmodule

// ----- tb/sv/tb_sorted_key_table_top.sv -----
// Testbench of sorted_key_table_top: directed and random requests, checked against
// an in-bench model of the key table. Depends on skt_pkg, skt_if and the RTL.
`timescale 1ns / 1ps

module tb_sorted_key_table_top;
	import skt_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;

	logic clk;
	logic arst_n;

	skt_req_if req_ch ();
	skt_rsp_if rsp_ch ();

	sorted_key_table_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// model state of the table
	logic [KEYIO_W-1:0] mdl_keys [DEPTH];
	int unsigned        mdl_used;

	// responses still to come, oldest first
	res_t pending_rsp [$];

	// idle percentages, changed per phase
	int unsigned send_idle_pct;
	int unsigned rsp_stall_pct;
	bit          failed;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hoare partition with midpoint pivot, pending subranges on an explicit stack
	task automatic model_sort(input int lo_s, input int hi_s);
		int stk_lo [$];
		int stk_hi [$];
		int left, right, i, j;
		logic [KEYIO_W-1:0] pivot, t;
		stk_lo.push_back(lo_s);
		stk_hi.push_back(hi_s);
		while (stk_lo.size() > 0) begin
			left = stk_lo.pop_back();
			right = stk_hi.pop_back();
			pivot = mdl_keys[(left + right) / 2];
			i = left;
			j = right;
			do begin
				while (i < right && mdl_keys[i] < pivot) i++;
				while (j > left && pivot < mdl_keys[j]) j--;
				if (j < i) break;
				t = mdl_keys[i];
				mdl_keys[i] = mdl_keys[j];
				mdl_keys[j] = t;
				i++;
				j--;
			end while (i <= j);
			if (left < j && stk_lo.size() < DEPTH) begin
				stk_lo.push_back(left);
				stk_hi.push_back(j);
			end
			if (i < right && stk_lo.size() < DEPTH) begin
				stk_lo.push_back(i);
				stk_hi.push_back(right);
			end
		end
	endtask

	// halve while span > 2, then scan for first key not below target
	function automatic bit model_find(input logic [KEYIO_W-1:0] target, input int lo,
			input int hi, output int where);
		int mid;
		where = 0;
		while (hi - lo > 2) begin
			mid = ((hi - lo) >> 1) + lo;
			if (target < mdl_keys[mid]) hi = mid;
			else lo = mid;
		end
		for (; lo <= hi; lo++) begin
			if (target <= mdl_keys[lo]) begin
				if (target == mdl_keys[lo]) begin
					where = lo;
					return 1'b1;
				end
				return 1'b0;
			end
		end
		return 1'b0;
	endfunction

	task automatic predict_table(input req_t r, output res_t e);
		int where;
		e = '0;
		e.status = ST_OK;
		case (r.operation)
			OP_SET: begin
				mdl_keys[r.entry_index] = r.key_value;
				if (r.entry_index >= mdl_used) mdl_used = r.entry_index + 1;
			end
			OP_REMOVE: begin
				if (r.entry_index >= mdl_used) e.status = ST_REJECT;
				else begin
					e.removed_key = mdl_keys[r.entry_index];
					mdl_keys[r.entry_index] = '0;
				end
			end
			default: begin
				if (r.range_low > r.range_high) e.status = ST_REJECT;
				else if (r.operation == OP_SORT) begin
					if (r.range_low < r.range_high) model_sort(r.range_low, r.range_high);
				end else if (model_find(r.key_value, r.range_low, r.range_high, where))
					e.found_index = where[IDX_W-1:0];
				else e.status = ST_MISSING;
			end
		endcase
	endtask

	// drive one request; valid is only lowered when an idle gap is inserted
	task automatic send_request(input req_t r);
		res_t e;
		if ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		req_ch.valid       <= 1'b1;
		req_ch.operation   <= r.operation;
		req_ch.entry_index <= r.entry_index;
		req_ch.key_value   <= r.key_value;
		req_ch.range_low   <= r.range_low;
		req_ch.range_high  <= r.range_high;
		do @(posedge clk); while (!req_ch.ready);
		predict_table(r, e);
		pending_rsp.push_back(e);
	endtask

	function automatic req_t make_req(input logic [OP_W-1:0] op, input int idx,
			input logic [KEYIO_W-1:0] key, input int lo, input int hi);
		req_t r;
		r.operation   = op;
		r.entry_index = idx[IDX_W-1:0];
		r.key_value   = key;
		r.range_low   = lo[IDX_W-1:0];
		r.range_high  = hi[IDX_W-1:0];
		return r;
	endfunction

	// sender pauses until every response is back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (pending_rsp.size() > 0) @(posedge clk);
		@(posedge clk);
	endtask

	// receiver side: random stall on ready
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response st=%0d idx=%0d key=%h", $time,
					rsp_ch.status, rsp_ch.found_index, rsp_ch.removed_key);
				failed = 1'b1;
			end else begin
				res_t e;
				e = pending_rsp.pop_front();
				if (rsp_ch.status !== e.status) begin
					$display("%0t: status exp %0d got %0d", $time, e.status, rsp_ch.status);
					failed = 1'b1;
				end
				if (rsp_ch.found_index !== e.found_index) begin
					$display("%0t: found_index exp %0d got %0d", $time, e.found_index,
						rsp_ch.found_index);
					failed = 1'b1;
				end
				if (rsp_ch.removed_key !== e.removed_key) begin
					$display("%0t: removed_key exp %h got %h", $time, e.removed_key,
						rsp_ch.removed_key);
					failed = 1'b1;
				end
			end
		end
	end

	// edge cases: empty table, key extremes, bad and single-slot ranges
	task automatic test_directed();
		send_request(make_req(OP_REMOVE, 5, 32'h0, 0, 0));          // beyond count
		send_request(make_req(OP_FIND, 0, 32'h0, 0, 0));            // single slot, empty
		send_request(make_req(OP_SET, 0, 32'h0, 0, 0));
		send_request(make_req(OP_SET, 255, 32'hFFFF_FFFF, 0, 0));
		send_request(make_req(OP_SET, 128, 32'h8000_0000, 0, 0));
		send_request(make_req(OP_SET, 1, 32'h5555_5555, 0, 0));
		send_request(make_req(OP_SET, 2, 32'hAAAA_AAAA, 0, 0));
		send_request(make_req(OP_REMOVE, 128, 32'h0, 0, 0));
		send_request(make_req(OP_REMOVE, 128, 32'h0, 0, 0));        // empty slot
		send_request(make_req(OP_SORT, 0, 32'h0, 10, 9));           // low above high
		send_request(make_req(OP_FIND, 0, 32'h0, 200, 3));
		send_request(make_req(OP_SORT, 0, 32'h0, 7, 7));            // single slot
		send_request(make_req(OP_SORT, 0, 32'h0, 0, 255));          // whole table
		send_request(make_req(OP_FIND, 0, 32'hFFFF_FFFF, 0, 255));
		send_request(make_req(OP_FIND, 0, 32'h5555_5555, 0, 255));
		send_request(make_req(OP_FIND, 0, 32'h1234_5678, 0, 255));  // missing
		send_request(make_req(OP_FIND, 0, 32'h0, 255, 255));
		send_request(make_req(OP_REMOVE, 255, 32'h0, 0, 0));
	endtask

	task automatic random_range(output int lo, output int hi);
		int w;
		case ($urandom_range(19))
			0: begin lo = $urandom_range(1, 255); hi = $urandom_range(lo - 1); end
			1: begin lo = 0; hi = 255; end
			2: begin lo = $urandom_range(255); hi = 255; end
			default: begin
				w = $urandom_range(15);
				lo = $urandom_range(255);
				hi = (lo + w > 255) ? 255 : lo + w;
			end
		endcase
	endtask

	// mostly set, sort, then find a stored key in the same range; rest is noise
	task automatic test_random(input int n_items, input int unsigned idle,
			input int unsigned stall);
		int lo, hi, idx, cnt;
		logic [KEYIO_W-1:0] key;
		send_idle_pct = idle;
		rsp_stall_pct = stall;
		cnt = 0;
		while (cnt < n_items) begin
			random_range(lo, hi);
			idx = $urandom_range(255);
			key = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom();
			case ($urandom_range(9))
				0, 1, 2: send_request(make_req(OP_SET, idx, key, $urandom_range(255),
					$urandom_range(255)));
				3: send_request(make_req(OP_REMOVE, idx, $urandom(), $urandom_range(255),
					$urandom_range(255)));
				4: send_request(make_req(OP_SORT, idx, key, lo, hi));
				5: send_request(make_req(OP_FIND, idx, key, lo, hi));
				default: begin
					send_request(make_req(OP_SORT, idx, key, lo, hi));
					if (lo <= hi && $urandom_range(3) != 0)
						key = mdl_keys[$urandom_range(hi, lo)];
					send_request(make_req(OP_FIND, idx, key, lo, hi));
					cnt++;
				end
			endcase
			cnt++;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		failed = 1'b0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		mdl_used = 0;
		foreach (mdl_keys[k]) mdl_keys[k] = '0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_SET;
		req_ch.entry_index = '0;
		req_ch.key_value = '0;
		req_ch.range_low = '0;
		req_ch.range_high = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		wait_drained();
		test_random(400, 0, 0);
		test_random(350, 87, 0);
		wait_drained();
		test_random(350, 0, 87);
		test_random(400, 19, 19);
		wait_drained();
		repeat (50) @(posedge clk);
		if (!failed) begin
			$display("[sorted_key_table_top] OK");
		end else begin
			$display("[sorted_key_table_top] ERROR");
		end
		$finish;
	end

	// run limit
	initial begin
		#40_000_000;
		$display("[sorted_key_table_top] ERROR");
		$finish;
	end

endmodule
